FILE: hw/rtl/fs4_iq_pulse_pair_freq_estimator_defines.svh
// Assertion macros for the fs/4 pulse-pair frequency estimator.
// Included by fs4_back, the RTL file that carries concurrent checks; no other dependencies.
`ifndef FS4_IQ_PULSE_PAIR_FREQ_ESTIMATOR_DEFINES_SVH
`define FS4_IQ_PULSE_PAIR_FREQ_ESTIMATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define FS4_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fs4 check failed (same cycle)");
// Consequent must hold in the cycle after the antecedent.
`define FS4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fs4 check failed (next cycle)");
`else
`define FS4_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FS4_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/fs4_pkg.sv
// Shared types, constants and the arctangent table for the fs/4 estimator.
// No dependencies; used by the front, queue glue, back end and top level.
`timescale 1ns / 1ps
`default_nettype none

package fs4_pkg;

  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int MAX_SAMPLES_DEF  = 65536;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int ACC_W       = 48;
  localparam int CNT_W       = 15;
  localparam int CNT_CAP     = 32767;
  localparam int FS_W        = 20;
  localparam int PHASE_W     = 16;
  localparam int FREQ_W      = 21;
  localparam int ANG_W       = 32;
  localparam int ATAN_IW     = 5;
  // Holds a negated full-scale sum after the CORDIC gain with margin.
  localparam int CORDIC_W    = 52;

  localparam logic [FS_W-1:0] FS_RESET = 20'd100000;

  // Control part of one queued item.
  typedef struct packed {
    logic             prod;
    logic             last;
    logic [CNT_W-1:0] count;
  } ctl_t;

  localparam int CTL_W = $bits(ctl_t);

  // atan(2^-i), 2^32 = 360 degrees.
  function automatic logic [ANG_W-1:0] atan_angle(input logic [ATAN_IW-1:0] i);
    logic [ANG_W-1:0] v;
    unique case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fs4_iq_pulse_pair_freq_estimator.sv
// fs/4 IQ demodulator with pulse-pair frequency estimate: top level.
// Uses fs4_pkg, fs4_front, fs4_queue and fs4_back.
//
// Usage:
//   Input channel in_valid/in_ready carries one real IF sample (in_sample)
//   per item; in_last marks the final sample of a block. Samples are taken
//   one per cycle while the four-entry queue between front and back has room.
//   Result channel out_valid/out_ready carries one item per block: phase of
//   the summed conjugate products, frequency estimate, both sums and the
//   product count. cfg_we/cfg_data set the sampling frequency in kHz.
//   After a block's last sample leaves the queue, the back end steps through
//   its wait, init, CORDIC rotate, phase and frequency states; out_valid
//   rises once the result register is free. One CORDIC iteration runs per
//   cycle, and no queue entries are popped until the result loads; the
//   front keeps taking samples until the queue fills.
//   A held result (out_ready low) does not stop accumulation of the next
//   block; it only delays that block's result until the register frees.
//   Reset (rst_n low, synchronous) clears all block state and sets the
//   sampling frequency to 100000 kHz.
`timescale 1ns / 1ps
`default_nettype none

module fs4_iq_pulse_pair_freq_estimator #(
  parameter int SAMPLE_BITS  = fs4_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_SAMPLES  = fs4_pkg::MAX_SAMPLES_DEF,
  parameter int CORDIC_STEPS = fs4_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [fs4_pkg::FS_W-1:0]             cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_sample,
  input  wire logic                                 in_last,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [fs4_pkg::PHASE_W-1:0]        out_phase_diff,
  output logic [fs4_pkg::FREQ_W-1:0]                out_freq_estimate_khz,
  output logic signed [fs4_pkg::ACC_W-1:0]          out_sum_real,
  output logic signed [fs4_pkg::ACC_W-1:0]          out_sum_imag,
  output logic [fs4_pkg::CNT_W-1:0]                 out_product_count
);

  localparam int DW = 4 * (SAMPLE_BITS + 1);
  localparam int QW = DW + fs4_pkg::CTL_W;

  logic          push, pop, q_full, q_empty;
  logic [DW-1:0] push_data;
  fs4_pkg::ctl_t push_ctl, pop_ctl;
  logic [QW-1:0] q_rd;

  fs4_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .in_last   (in_last),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data),
    .push_ctl  (push_ctl)
  );

  fs4_queue #(
    .DATA_W (QW),
    .DEPTH  (fs4_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data ({push_ctl, push_data}),
    .rd_en   (pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  assign pop_ctl = fs4_pkg::ctl_t'(q_rd[QW-1:DW]);

  fs4_back #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_data              (cfg_data),
    .q_empty               (q_empty),
    .pop                   (pop),
    .pop_data              (q_rd[DW-1:0]),
    .pop_ctl               (pop_ctl),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_phase_diff        (out_phase_diff),
    .out_freq_estimate_khz (out_freq_estimate_khz),
    .out_sum_real          (out_sum_real),
    .out_sum_imag          (out_sum_imag),
    .out_product_count     (out_product_count)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/fs4_front.sv
// Front end: takes samples, pairs them into IQ values and forms the operands
// of each conjugate product. Depends on fs4_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fs4_front #(
  parameter int SAMPLE_BITS = fs4_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_SAMPLES = fs4_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          in_last,
  input  wire logic                          q_full,
  output logic                               push,
  output logic [4*(SAMPLE_BITS+1)-1:0]       push_data,
  output fs4_pkg::ctl_t                      push_ctl
);

  localparam int OW        = SAMPLE_BITS + 1;
  localparam int RAW_LIMIT = MAX_SAMPLES / 2 - 1;
  localparam int LIMIT     = (RAW_LIMIT > fs4_pkg::CNT_CAP) ? fs4_pkg::CNT_CAP : RAW_LIMIT;
  localparam logic [fs4_pkg::CNT_W-1:0] LIMIT_C = fs4_pkg::CNT_W'(LIMIT);

  logic [1:0]                          pos_r, pos_nxt;
  logic signed [SAMPLE_BITS-1:0]       held_r, held_nxt;
  logic signed [SAMPLE_BITS-1:0]       prev_i_r, prev_i_nxt;
  logic signed [SAMPLE_BITS-1:0]       prev_q_r, prev_q_nxt;
  logic                                have_prev_r, have_prev_nxt;
  logic [fs4_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;

  logic signed [OW-1:0] s_ext, held_ext, pi_ext, pq_ext;
  logic signed [OW-1:0] op_a, op_b, op_c, op_d;
  logic                 second, pair, prod, accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign s_ext    = {in_sample[SAMPLE_BITS-1], in_sample};
  assign held_ext = {held_r[SAMPLE_BITS-1], held_r};
  assign pi_ext   = {prev_i_r[SAMPLE_BITS-1], prev_i_r};
  assign pq_ext   = {prev_q_r[SAMPLE_BITS-1], prev_q_r};

  assign pair   = pos_r[0];
  assign second = (pos_r == 2'd3);
  assign prod   = pair && have_prev_r && (cnt_r < LIMIT_C);

  // Second half of a group carries negated samples; conjugate flips the partner.
  assign op_a = second ? -held_ext : held_ext;
  assign op_b = second ? -s_ext    : s_ext;
  assign op_c = second ? pi_ext    : -pi_ext;
  assign op_d = second ? pq_ext    : -pq_ext;

  assign push           = accept && (prod || in_last);
  assign push_data      = {op_a, op_b, op_c, op_d};
  assign push_ctl.prod  = prod;
  assign push_ctl.last  = in_last;
  assign push_ctl.count = cnt_r + (prod ? fs4_pkg::CNT_W'(1) : fs4_pkg::CNT_W'(0));

  always_comb begin
    pos_nxt       = pos_r;
    held_nxt      = held_r;
    prev_i_nxt    = prev_i_r;
    prev_q_nxt    = prev_q_r;
    have_prev_nxt = have_prev_r;
    cnt_nxt       = cnt_r;
    if (accept) begin
      if (in_last) begin
        // End of block: start the next one clean.
        pos_nxt       = 2'd0;
        held_nxt      = '0;
        prev_i_nxt    = '0;
        prev_q_nxt    = '0;
        have_prev_nxt = 1'b0;
        cnt_nxt       = '0;
      end else begin
        pos_nxt = pos_r + 2'd1;
        if (!pair) begin
          held_nxt = in_sample;
        end else begin
          prev_i_nxt    = held_r;
          prev_q_nxt    = in_sample;
          have_prev_nxt = 1'b1;
          cnt_nxt       = push_ctl.count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 2'd0;
      held_r      <= '0;
      prev_i_r    <= '0;
      prev_q_r    <= '0;
      have_prev_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      pos_r       <= pos_nxt;
      held_r      <= held_nxt;
      prev_i_r    <= prev_i_nxt;
      prev_q_r    <= prev_q_nxt;
      have_prev_r <= have_prev_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fs4_queue.sv
// Short first-in first-out queue between the front end and the back end.
// Generic data width; depth from fs4_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fs4_queue #(
  parameter int DATA_W = 4 * (fs4_pkg::SAMPLE_BITS_DEF + 1) + fs4_pkg::CTL_W,
  parameter int DEPTH  = fs4_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  output logic [DATA_W-1:0]      rd_data,
  output logic                   full,
  output logic                   empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    cnt_nxt = cnt_r + CW'(do_wr) - CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fs4_back.sv
// Back end: multiply-accumulate of conjugate products, vectoring CORDIC,
// frequency scaling and the result register. Depends on fs4_pkg and the defines.
`timescale 1ns / 1ps
`default_nettype none
`include "fs4_iq_pulse_pair_freq_estimator_defines.svh"

module fs4_back #(
  parameter int SAMPLE_BITS  = fs4_pkg::SAMPLE_BITS_DEF,
  parameter int CORDIC_STEPS = fs4_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [fs4_pkg::FS_W-1:0]             cfg_data,
  input  wire logic                                 q_empty,
  output logic                                      pop,
  input  wire logic [4*(SAMPLE_BITS+1)-1:0]         pop_data,
  input  wire fs4_pkg::ctl_t                        pop_ctl,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [fs4_pkg::PHASE_W-1:0]        out_phase_diff,
  output logic [fs4_pkg::FREQ_W-1:0]                out_freq_estimate_khz,
  output logic signed [fs4_pkg::ACC_W-1:0]          out_sum_real,
  output logic signed [fs4_pkg::ACC_W-1:0]          out_sum_imag,
  output logic [fs4_pkg::CNT_W-1:0]                 out_product_count
);

  localparam int OW    = SAMPLE_BITS + 1;
  localparam int PW    = 2 * OW;
  localparam int EXT_W = ((PW + 2) > (fs4_pkg::ACC_W + 1)) ? (PW + 2) : (fs4_pkg::ACC_W + 1);
  localparam int CW    = fs4_pkg::CORDIC_W;
  localparam int AW    = fs4_pkg::ACC_W;
  localparam int ITW   = $clog2(CORDIC_STEPS);

  localparam logic signed [EXT_W-1:0] ACC_MAX = EXT_W'($signed({1'b0, {(AW-1){1'b1}}}));
  localparam logic signed [EXT_W-1:0] ACC_MIN = EXT_W'($signed({1'b1, {(AW-1){1'b0}}}));

  typedef enum logic [5:0] {
    S_ACC  = 6'b000001,
    S_WAIT = 6'b000010,
    S_INIT = 6'b000100,
    S_ROT  = 6'b001000,
    S_PHS  = 6'b010000,
    S_FRQ  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [fs4_pkg::FS_W-1:0] fs_r;

  // Multiply stage
  logic                 m_vld_r;
  fs4_pkg::ctl_t        m_ctl_r;
  logic signed [PW-1:0] m_ac_r, m_bd_r, m_bc_r, m_ad_r;
  logic signed [OW-1:0] op_a, op_b, op_c, op_d;

  // Accumulators
  logic signed [AW-1:0]    acc_re_r, acc_im_r;
  logic signed [EXT_W-1:0] sum_re, sum_im, ext_re, ext_im;
  logic signed [AW-1:0]    sat_re, sat_im;
  logic [fs4_pkg::CNT_W-1:0] cnt_r;

  // CORDIC
  logic signed [CW-1:0]        cx_r, cy_r, cx_ld, cy_ld, xs, ys;
  logic [fs4_pkg::ANG_W-1:0]   ang_r, atan_v, ang_rnd;
  logic [ITW-1:0]              iter_r;
  logic                        zero_r;
  logic signed [fs4_pkg::PHASE_W-1:0] phase_r;

  // Frequency
  logic [fs4_pkg::PHASE_W-1:0]                   ph_off;
  logic [fs4_pkg::FS_W+fs4_pkg::PHASE_W-1:0]     fprod;
  logic [fs4_pkg::FS_W+fs4_pkg::PHASE_W:0]       fsum;

  // Result register
  logic                                out_vld_r;
  logic signed [fs4_pkg::PHASE_W-1:0]  o_phase_r;
  logic [fs4_pkg::FREQ_W-1:0]          o_freq_r;
  logic signed [AW-1:0]                o_re_r, o_im_r;
  logic [fs4_pkg::CNT_W-1:0]           o_cnt_r;
  logic                                load_out;

  assign {op_a, op_b, op_c, op_d} = pop_data;

  assign pop      = (state_r == S_ACC) && !q_empty;
  assign load_out = (state_r == S_FRQ) && (!out_vld_r || out_ready);

  // (a+jb)(c-jd) with c, d already conjugated by the front end.
  assign sum_re = EXT_W'(m_ac_r) + EXT_W'(m_bd_r);
  assign sum_im = EXT_W'(m_bc_r) - EXT_W'(m_ad_r);
  assign ext_re = EXT_W'(acc_re_r) + sum_re;
  assign ext_im = EXT_W'(acc_im_r) + sum_im;

  always_comb begin
    priority if (ext_re > ACC_MAX) sat_re = ACC_MAX[AW-1:0];
    else if (ext_re < ACC_MIN)     sat_re = ACC_MIN[AW-1:0];
    else                           sat_re = ext_re[AW-1:0];
    priority if (ext_im > ACC_MAX) sat_im = ACC_MAX[AW-1:0];
    else if (ext_im < ACC_MIN)     sat_im = ACC_MIN[AW-1:0];
    else                           sat_im = ext_im[AW-1:0];
  end

  assign cx_ld  = CW'(acc_re_r);
  assign cy_ld  = CW'(acc_im_r);
  assign xs     = cx_r >>> iter_r;
  assign ys     = cy_r >>> iter_r;
  assign atan_v = fs4_pkg::atan_angle(fs4_pkg::ATAN_IW'(iter_r));
  assign ang_rnd = ang_r + 32'h0000_8000;

  // 32768 + phase over the signed range is the phase with its sign bit flipped.
  assign ph_off = {~phase_r[fs4_pkg::PHASE_W-1], phase_r[fs4_pkg::PHASE_W-2:0]};
  assign fprod  = fs_r * ph_off;
  assign fsum   = {1'b0, fprod} + (fs4_pkg::FS_W+fs4_pkg::PHASE_W+1)'(16384);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_ACC:  if (pop && pop_ctl.last) state_nxt = S_WAIT;
      S_WAIT: state_nxt = S_INIT;
      S_INIT: state_nxt = S_ROT;
      S_ROT:  if (iter_r == ITW'(CORDIC_STEPS - 1)) state_nxt = S_PHS;
      S_PHS:  state_nxt = S_FRQ;
      S_FRQ:  if (load_out) state_nxt = S_ACC;
      default: state_nxt = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_ACC;
      fs_r      <= fs4_pkg::FS_RESET;
      m_vld_r   <= 1'b0;
      acc_re_r  <= '0;
      acc_im_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      m_vld_r <= pop;
      if (cfg_we) begin
        fs_r <= cfg_data;
      end
      if (load_out) begin
        acc_re_r <= '0;
        acc_im_r <= '0;
      end else if (m_vld_r && m_ctl_r.prod) begin
        acc_re_r <= sat_re;
        acc_im_r <= sat_im;
      end
      if (load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_ctl_r <= pop_ctl;
      m_ac_r  <= op_a * op_c;
      m_bd_r  <= op_b * op_d;
      m_bc_r  <= op_b * op_c;
      m_ad_r  <= op_a * op_d;
    end
    if (m_vld_r && m_ctl_r.last) begin
      cnt_r <= m_ctl_r.count;
    end
    if (state_r == S_INIT) begin
      zero_r <= (acc_re_r == '0) && (acc_im_r == '0);
      iter_r <= '0;
      // Fold the left half-plane into the right before vectoring.
      if (acc_re_r < 0) begin
        cx_r  <= -cx_ld;
        cy_r  <= -cy_ld;
        ang_r <= 32'h8000_0000;
      end else begin
        cx_r  <= cx_ld;
        cy_r  <= cy_ld;
        ang_r <= '0;
      end
    end else if (state_r == S_ROT) begin
      iter_r <= iter_r + ITW'(1);
      if (!cy_r[CW-1]) begin
        cx_r  <= cx_r + ys;
        cy_r  <= cy_r - xs;
        ang_r <= ang_r + atan_v;
      end else begin
        cx_r  <= cx_r - ys;
        cy_r  <= cy_r + xs;
        ang_r <= ang_r - atan_v;
      end
    end
    if (state_r == S_PHS) begin
      phase_r <= zero_r ? '0 : $signed(ang_rnd[fs4_pkg::ANG_W-1:fs4_pkg::ANG_W-fs4_pkg::PHASE_W]);
    end
    if (load_out) begin
      o_phase_r <= phase_r;
      o_freq_r  <= fsum[fs4_pkg::FREQ_W+14:15];
      o_re_r    <= acc_re_r;
      o_im_r    <= acc_im_r;
      o_cnt_r   <= cnt_r;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_phase_diff        = o_phase_r;
  assign out_freq_estimate_khz = o_freq_r;
  assign out_sum_real          = o_re_r;
  assign out_sum_imag          = o_im_r;
  assign out_product_count     = o_cnt_r;

  `FS4_ASSERT_SAME(a_last_in_mult_waits, clk, rst_n, m_vld_r && m_ctl_r.last, state_r == S_WAIT)
  `FS4_ASSERT_NEXT(a_init_starts_rot, clk, rst_n, state_r == S_INIT, (state_r == S_ROT) && (iter_r == '0))
  `FS4_ASSERT_NEXT(a_rot_ends, clk, rst_n, (state_r == S_ROT) && (iter_r == ITW'(CORDIC_STEPS - 1)), state_r == S_PHS)
  `FS4_ASSERT_NEXT(a_load_clears, clk, rst_n, load_out, out_vld_r && (acc_re_r == '0) && (acc_im_r == '0))

endmodule

`default_nettype wire
